>>> design/sdkm_pkg.sv
// ----------------------------------------------------------------------------
// sdkm_pkg
// Types, constants and helper functions of the spline derivative kernel
// matrix block: double unpacking, leading-zero counts, falling factorials.
// ----------------------------------------------------------------------------
package sdkm_pkg;

  localparam int unsigned MAX_TERMS  = 8;
  localparam int unsigned XP_N       = 2 * MAX_TERMS - 2;
  localparam int unsigned XP_W       = $clog2(XP_N);
  localparam logic [XP_W-1:0] POW_LAST = XP_W'(XP_N - 1);
  localparam int unsigned DIV_STAGES = 8;
  localparam int unsigned DIV_STEPS  = 8;

  localparam logic [63:0] FP_ONE     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP_DEF_NAN = 64'hFFF8_0000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POW  = 3'b010,
    ST_ENT  = 3'b100
  } state_e;

  typedef enum logic {
    KIND_POW = 1'b0,
    KIND_ENT = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e      kind;
    logic [XP_W-1:0] pidx;
    logic [2:0]      row;
    logic [2:0]      col;
    logic            last;
    logic            zero;
  } tag_t;

  typedef struct packed {
    logic               sign;
    logic signed [12:0] exp;
    logic [52:0]        mant;
    logic               zero;
    logic               inf;
    logic               nan;
  } fp_unp_t;

  typedef struct packed {
    logic [3:0]  rem;
    logic [63:0] num;
  } div_t;

  function automatic logic [7:0] falling(logic [2:0] m, logic [1:0] k);
    logic [7:0] prod;
    prod = 8'd1;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(k)) prod = 8'(prod * (8'(m) - 8'(i)));
    end
    return prod;
  endfunction

  function automatic logic [3:0] lzc16(logic [15:0] v);
    logic [3:0] lz;
    logic       found;
    lz    = 4'd0;
    found = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else lz = lz + 4'd1;
      end
    end
    return lz;
  endfunction

  function automatic fp_unp_t fp_unpack(logic [63:0] v);
    fp_unp_t     u;
    logic [10:0] e;
    logic [51:0] f;
    logic [5:0]  lz;
    logic        found;
    e      = v[62:52];
    f      = v[51:0];
    u.sign = v[63];
    u.nan  = (e == 11'h7FF) && (f != 52'd0);
    u.inf  = (e == 11'h7FF) && (f == 52'd0);
    u.zero = (e == 11'd0) && (f == 52'd0);
    lz     = 6'd0;
    found  = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found) begin
        if (f[i]) found = 1'b1;
        else lz = lz + 6'd1;
      end
    end
    if (e == 11'd0) begin
      u.mant = {1'b0, f} << (7'(lz) + 7'd1);
      u.exp  = -$signed({7'b0, lz});
    end else begin
      u.mant = {1'b1, f};
      u.exp  = $signed({2'b0, e});
    end
    return u;
  endfunction

  function automatic div_t div_step8(div_t d, logic [3:0] pn);
    div_t       r;
    logic [4:0] t;
    logic       q;
    r = d;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {r.rem, r.num[63]};
      q     = (t >= {1'b0, pn});
      r.rem = q ? 4'(t - {1'b0, pn}) : t[3:0];
      r.num = {r.num[62:0], q};
    end
    return r;
  endfunction

endpackage

>>> design/spline_derivative_kernel_matrix.sv
// ----------------------------------------------------------------------------
// spline_derivative_kernel_matrix
// Streams the n x n kernel matrix of the squared k-th derivative over one
// polynomial segment, one double entry per beat in row-major order.
// ----------------------------------------------------------------------------
// Per request, the 13 powers of x are formed one after another in the
// pipelined double multiplier, each written back before the next is read;
// then the n*n entries stream out at one per cycle, unless the output
// stalls, through a divide pipeline (eight stages) with a per-entry divisor
// and the same multiplier. The next request is taken once every entry of
// the previous one has read its power of x.
module spline_derivative_kernel_matrix
  import sdkm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // deriv_order[1:0], num_terms[5:2], seg_length[69:6], zero pad
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // entry_value[63:0], row_index[66:64], col_index[69:67], zero pad
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  logic en;
  state_e state_q, state_d;
  logic [1:0]      k_q, k_d;
  logic [3:0]      n_q, n_d;
  logic [63:0]     x_q, x_d;
  logic [XP_W-1:0] pow_idx_q, pow_idx_d;
  logic            pow_busy_q, pow_busy_d;
  logic [2:0]      row_q, row_d, col_q, col_d;

  logic [63:0] xp_q [XP_N];

  // issue stage
  logic        iss_v_q;
  tag_t        iss_tag_q, iss_tag_d;
  logic [15:0] iss_a_q, iss_a_d;
  logic [3:0]  iss_p_q, iss_p_d;

  // divide pipeline
  logic [DIV_STAGES:0] dv_v_q;
  tag_t                dv_tag_q  [DIV_STAGES+1];
  div_t                dv_q      [DIV_STAGES+1];
  div_t                dv_d      [DIV_STAGES+1];
  logic [3:0]          dv_pn_q   [DIV_STAGES+1];
  logic [10:0]         dv_kexp_q [DIV_STAGES+1];

  // kernel value stage
  logic        kv_q;
  tag_t        kv_tag_q;
  logic [63:0] kern_q, kern_d;

  // multiplier stages
  logic        m0_v_q, m1_v_q, m2_v_q, m3_v_q, m4_v_q;
  tag_t        m0_tag_q, m1_tag_q, m2_tag_q, m3_tag_q, m4_tag_q, m0_tag_d;
  logic [63:0] m0_a_q, m0_b_q, m0_a_d, m0_b_d;
  logic        m1_sign_q, m2_sign_q, m3_sign_q, m4_sign_q;
  logic        m1_spec_q, m2_spec_q, m3_spec_q, m4_spec_q, m1_spec_d;
  logic [63:0] m1_sval_q, m2_sval_q, m3_sval_q, m4_sval_q, m1_sval_d;
  logic [52:0] m1_ma_q, m1_mb_q;
  logic signed [12:0] m1_e_q, m2_e_q, m3_e_q, m1_e_d;
  logic [53:0]  m2_ll_q;
  logic [52:0]  m2_lh_q, m2_hl_q;
  logic [51:0]  m2_hh_q;
  logic [105:0] m3_p_q;
  logic [10:0]  m4_field_q, m4_field_d;
  logic [51:0]  m4_frac_q, m4_frac_d;
  logic         m4_g_q, m4_g_d, m4_s_q, m4_s_d, m4_ovf_q, m4_ovf_d;

  // output register
  logic        m_v_q;
  logic [63:0] m_val_q;
  logic [2:0]  m_row_q, m_col_q;
  logic        m_last_q;

  logic            pre_busy, pow_go, pow_wr, s_acc, ent_last;
  logic [63:0]     round_res;
  logic [XP_W-1:0] rd_idx;
  logic [63:0]     rd_val;

  assign en       = !m_v_q || m_axis_tready_i;
  assign pre_busy = iss_v_q || (|dv_v_q) || kv_q;
  assign s_axis_tready_o = (state_q == ST_IDLE) && !pre_busy;
  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign pow_go   = (state_q == ST_POW) && !pow_busy_q && !kv_q;
  assign pow_wr   = en && m4_v_q && (m4_tag_q.kind == KIND_POW);
  assign ent_last = (row_q == 3'(n_q - 4'd1)) && (col_q == 3'(n_q - 4'd1));

  // sequencer
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    n_d        = n_q;
    x_d        = x_q;
    pow_idx_d  = pow_idx_q;
    pow_busy_d = pow_busy_q;
    row_d      = row_q;
    col_d      = col_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          k_d       = s_axis_tdata_i[1:0];
          n_d       = (s_axis_tdata_i[5:2] > 4'(MAX_TERMS)) ? 4'(MAX_TERMS)
                                                            : s_axis_tdata_i[5:2];
          x_d       = s_axis_tdata_i[69:6];
          pow_idx_d = XP_W'(1);
          if (s_axis_tdata_i[5:2] != 4'd0) state_d = ST_POW;
        end
      end
      ST_POW: begin
        if (en && pow_go) pow_busy_d = 1'b1;
        if (pow_wr) begin
          pow_busy_d = 1'b0;
          if (m4_tag_q.pidx == POW_LAST) begin
            state_d = ST_ENT;
            row_d   = 3'd0;
            col_d   = 3'd0;
          end else begin
            pow_idx_d = pow_idx_q + XP_W'(1);
          end
        end
      end
      ST_ENT: begin
        if (en) begin
          if (ent_last) begin
            state_d = ST_IDLE;
          end else if (col_q == 3'(n_q - 4'd1)) begin
            col_d = 3'd0;
            row_d = row_q + 3'd1;
          end else begin
            col_d = col_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // issue stage values
  always_comb begin
    logic [4:0] p5;
    p5 = {2'b0, row_q} + {2'b0, col_q} + 5'd1 - {2'b0, k_q, 1'b0};
    iss_tag_d.kind = KIND_ENT;
    iss_tag_d.row  = row_q;
    iss_tag_d.col  = col_q;
    iss_tag_d.last = ent_last;
    iss_tag_d.zero = (k_q == 2'd0) || (row_q < {1'b0, k_q}) || (col_q < {1'b0, k_q});
    iss_tag_d.pidx = XP_W'(p5);
    iss_a_d = 16'({8'b0, falling(row_q, k_q)} * {8'b0, falling(col_q, k_q)});
    iss_p_d = p5[3:0];
    if (iss_tag_d.zero) begin
      iss_a_d        = 16'd1;
      iss_p_d        = 4'd1;
      iss_tag_d.pidx = XP_W'(1);
    end
  end

  // divide pipeline next values
  always_comb begin
    logic [3:0] lza;
    lza = lzc16(iss_a_q);
    dv_d[0].rem = 4'd0;
    dv_d[0].num = {16'(iss_a_q << lza), 48'b0};
    for (int s = 1; s <= DIV_STAGES; s++) begin
      dv_d[s] = div_step8(dv_q[s-1], dv_pn_q[s-1]);
    end
  end

  // kernel rounding
  always_comb begin
    logic [63:0] q;
    logic [10:0] fld;
    logic [51:0] frc;
    logic        g, s, inc;
    q = dv_q[DIV_STAGES].num;
    if (q[60]) begin
      fld = dv_kexp_q[DIV_STAGES] + 11'd1;
      frc = q[59:8];
      g   = q[7];
      s   = (|q[6:0]) || (dv_q[DIV_STAGES].rem != 4'd0);
    end else begin
      fld = dv_kexp_q[DIV_STAGES];
      frc = q[58:7];
      g   = q[6];
      s   = (|q[5:0]) || (dv_q[DIV_STAGES].rem != 4'd0);
    end
    inc    = g && (s || frc[0]);
    kern_d = {1'b0, 63'({fld, frc} + 63'(inc))};
  end

  // operand select into the multiplier
  assign rd_idx = kv_q ? kv_tag_q.pidx : pow_idx_q - XP_W'(1);
  assign rd_val = (rd_idx == XP_W'(0)) ? FP_ONE : xp_q[rd_idx];

  always_comb begin
    m0_a_d = rd_val;
    if (kv_q) begin
      m0_b_d   = kern_q;
      m0_tag_d = kv_tag_q;
    end else begin
      m0_b_d        = x_q;
      m0_tag_d      = '0;
      m0_tag_d.kind = KIND_POW;
      m0_tag_d.pidx = pow_idx_q;
    end
  end

  // unpack and special values
  fp_unp_t ua, ub;
  always_comb begin
    logic sgn;
    ua  = fp_unpack(m0_a_q);
    ub  = fp_unpack(m0_b_q);
    sgn = m0_a_q[63] ^ m0_b_q[63];
    m1_e_d    = ua.exp + ub.exp - 13'sd1023;
    m1_spec_d = 1'b1;
    if (ua.nan) begin
      m1_sval_d = m0_a_q | 64'h0008_0000_0000_0000;
    end else if (ub.nan) begin
      m1_sval_d = m0_b_q | 64'h0008_0000_0000_0000;
    end else if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
      m1_sval_d = FP_DEF_NAN;
    end else if (ua.inf || ub.inf) begin
      m1_sval_d = {sgn, 11'h7FF, 52'd0};
    end else if (ua.zero || ub.zero) begin
      m1_sval_d = {sgn, 63'd0};
    end else begin
      m1_spec_d = 1'b0;
      m1_sval_d = 64'd0;
    end
  end

  // normalize, place subnormals, collect guard and sticky
  always_comb begin
    logic               hi;
    logic [105:0]       pn, sft;
    logic signed [12:0] eh, shd;
    logic [5:0]         sh;
    logic               lost;
    hi  = m3_p_q[105];
    pn  = hi ? m3_p_q : {m3_p_q[104:0], 1'b0};
    eh  = m3_e_q + $signed({12'b0, hi});
    shd = 13'sd1 - eh;
    m4_ovf_d = (eh > 13'sd2046);
    if (eh > 13'sd0) begin
      sh         = 6'd0;
      m4_field_d = eh[10:0];
    end else begin
      sh         = (shd > 13'sd63) ? 6'd63 : shd[5:0];
      m4_field_d = 11'd0;
    end
    sft  = pn >> sh;
    lost = |(pn & ((106'd1 << sh) - 106'd1));
    m4_frac_d = sft[104:53];
    m4_g_d    = sft[52];
    m4_s_d    = (|sft[51:0]) || lost;
  end

  // rounding to nearest even
  always_comb begin
    logic inc;
    inc = m4_g_q && (m4_s_q || m4_frac_q[0]);
    if (m4_spec_q) begin
      round_res = m4_sval_q;
    end else if (m4_ovf_q) begin
      round_res = {m4_sign_q, 11'h7FF, 52'd0};
    end else begin
      round_res = {m4_sign_q, 63'({m4_field_q, m4_frac_q} + 63'(inc))};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pow_busy_q <= 1'b0;
      iss_v_q    <= 1'b0;
      dv_v_q     <= '0;
      kv_q       <= 1'b0;
      m0_v_q     <= 1'b0;
      m1_v_q     <= 1'b0;
      m2_v_q     <= 1'b0;
      m3_v_q     <= 1'b0;
      m4_v_q     <= 1'b0;
      m_v_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      pow_busy_q <= pow_busy_d;
      if (en) begin
        iss_v_q <= (state_q == ST_ENT);
        dv_v_q  <= {dv_v_q[DIV_STAGES-1:0], iss_v_q};
        kv_q    <= dv_v_q[DIV_STAGES];
        m0_v_q  <= kv_q || pow_go;
        m1_v_q  <= m0_v_q;
        m2_v_q  <= m1_v_q;
        m3_v_q  <= m2_v_q;
        m4_v_q  <= m3_v_q;
        m_v_q   <= m4_v_q && (m4_tag_q.kind == KIND_ENT);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    n_q       <= n_d;
    x_q       <= x_d;
    pow_idx_q <= pow_idx_d;
    row_q     <= row_d;
    col_q     <= col_d;
    if (pow_wr) xp_q[m4_tag_q.pidx] <= round_res;
    if (en) begin
      iss_tag_q <= iss_tag_d;
      iss_a_q   <= iss_a_d;
      iss_p_q   <= iss_p_d;

      dv_q[0]      <= dv_d[0];
      dv_tag_q[0]  <= iss_tag_q;
      dv_pn_q[0]   <= iss_p_q << 2'(lzc16({iss_p_q, 12'b0}));
      dv_kexp_q[0] <= 11'd1034 + {9'b0, 2'(lzc16({iss_p_q, 12'b0}))}
                      - {7'b0, lzc16(iss_a_q)};
      for (int s = 1; s <= DIV_STAGES; s++) begin
        dv_q[s]      <= dv_d[s];
        dv_tag_q[s]  <= dv_tag_q[s-1];
        dv_pn_q[s]   <= dv_pn_q[s-1];
        dv_kexp_q[s] <= dv_kexp_q[s-1];
      end

      kv_tag_q <= dv_tag_q[DIV_STAGES];
      kern_q   <= kern_d;

      m0_a_q   <= m0_a_d;
      m0_b_q   <= m0_b_d;
      m0_tag_q <= m0_tag_d;

      m1_tag_q  <= m0_tag_q;
      m1_sign_q <= m0_a_q[63] ^ m0_b_q[63];
      m1_spec_q <= m1_spec_d;
      m1_sval_q <= m1_sval_d;
      m1_ma_q   <= ua.mant;
      m1_mb_q   <= ub.mant;
      m1_e_q    <= m1_e_d;

      m2_tag_q  <= m1_tag_q;
      m2_sign_q <= m1_sign_q;
      m2_spec_q <= m1_spec_q;
      m2_sval_q <= m1_sval_q;
      m2_e_q    <= m1_e_q;
      m2_ll_q   <= {27'b0, m1_ma_q[26:0]} * {27'b0, m1_mb_q[26:0]};
      m2_lh_q   <= {26'b0, m1_ma_q[26:0]} * {27'b0, m1_mb_q[52:27]};
      m2_hl_q   <= {27'b0, m1_ma_q[52:27]} * {26'b0, m1_mb_q[26:0]};
      m2_hh_q   <= {26'b0, m1_ma_q[52:27]} * {26'b0, m1_mb_q[52:27]};

      m3_tag_q  <= m2_tag_q;
      m3_sign_q <= m2_sign_q;
      m3_spec_q <= m2_spec_q;
      m3_sval_q <= m2_sval_q;
      m3_e_q    <= m2_e_q;
      m3_p_q    <= ({54'b0, m2_hh_q} << 54)
                 + (({53'b0, m2_lh_q} + {53'b0, m2_hl_q}) << 27)
                 + {52'b0, m2_ll_q};

      m4_tag_q   <= m3_tag_q;
      m4_sign_q  <= m3_sign_q;
      m4_spec_q  <= m3_spec_q;
      m4_sval_q  <= m3_sval_q;
      m4_field_q <= m4_field_d;
      m4_frac_q  <= m4_frac_d;
      m4_g_q     <= m4_g_d;
      m4_s_q     <= m4_s_d;
      m4_ovf_q   <= m4_ovf_d;

      m_val_q  <= m4_tag_q.zero ? 64'd0 : round_res;
      m_row_q  <= m4_tag_q.row;
      m_col_q  <= m4_tag_q.col;
      m_last_q <= m4_tag_q.last;
    end
  end

  assign m_axis_tvalid_o = m_v_q;
  assign m_axis_tdata_o  = {2'b0, m_col_q, m_row_q, m_val_q};
  assign m_axis_tlast_o  = m_last_q;

  ap_pow_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pow_wr |-> state_q == ST_POW)
    else $error("power write-back outside power phase");

  ap_no_entry_in_pow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POW |-> !kv_q)
    else $error("entry reached operand read while powers pending");

  ap_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_row_q == m_col_q)
    else $error("last beat off the diagonal");

endmodule
